@@ hdl/dswf_pkg.sv @@
// ----------------------------------------------------------------------------
// dswf_pkg
// Shared types and codes for the duplicate sequence window filter.
// ----------------------------------------------------------------------------
package dswf_pkg;

    localparam int SEQ_W = 16;
    localparam int OUTCOME_W = 3;
    localparam logic [4:0] RESTART_LIMIT = 5'd16;
    localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h8000;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_NEW       = 3'd0,
        OC_NEWER     = 3'd1,
        OC_IN_WINDOW = 3'd2,
        OC_DUPLICATE = 3'd3,
        OC_TOO_OLD   = 3'd4,
        OC_RESTART   = 3'd5,
        OC_FULL      = 3'd6
    } outcome_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word, clear search index
        logic rd;        // issue read at search index
        logic adv;       // step search index
        logic alloc;     // write fresh entry at fill count
        logic update;    // write back updated matched entry
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // entry read last cycle matches
        logic last;      // search index at final entry
        logic full;      // no free entry
    } dp_sts_t;

endpackage

@@ hdl/dswf_datapath.sv @@
// ----------------------------------------------------------------------------
// dswf_datapath
// Entry table memories, address compare and window update logic.
// ----------------------------------------------------------------------------
module dswf_datapath #(
    parameter int ENTRIES     = 64,
    parameter int WINDOW_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ipv6_mode,
    input  logic [63:0]        in_addr_high,
    input  logic [63:0]        in_addr_low,
    input  logic [15:0]        in_seq,
    input  dswf_pkg::dp_cmd_t  cmd,
    output dswf_pkg::dp_sts_t  sts,
    output logic               res_accept,
    output logic [2:0]         res_outcome
);
    import dswf_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SH_W  = $clog2(WINDOW_BITS);

    logic [63:0]            mem_hi  [ENTRIES];
    logic [63:0]            mem_lo  [ENTRIES];
    logic [15:0]            mem_seq [ENTRIES];
    logic [WINDOW_BITS-1:0] mem_win [ENTRIES];
    logic [4:0]             mem_cnt [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;

    logic [CNT_W-1:0] fill_reg;
    logic [IDX_W-1:0] idx_reg, ridx_reg;
    logic [63:0] a_hi_reg, a_lo_reg;
    logic [15:0] seq_reg;
    logic [63:0] r_hi_reg, r_lo_reg;
    logic [15:0] r_seq_reg;
    logic [WINDOW_BITS-1:0] r_win_reg;
    logic [4:0] r_cnt_reg;
    logic r_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.adv) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.alloc) begin
                valid_reg[fill_reg[IDX_W-1:0]] <= 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_hi_reg <= in_addr_high;
            a_lo_reg <= in_addr_low;
            seq_reg  <= in_seq;
        end
        if (cmd.rd) begin
            r_hi_reg  <= mem_hi[idx_reg];
            r_lo_reg  <= mem_lo[idx_reg];
            r_seq_reg <= mem_seq[idx_reg];
            r_win_reg <= mem_win[idx_reg];
            r_cnt_reg <= mem_cnt[idx_reg];
            r_val_reg <= valid_reg[idx_reg];
            ridx_reg  <= idx_reg;
        end
    end

    assign sts.hit = r_val_reg && (ipv6_mode ?
        (r_hi_reg == a_hi_reg && r_lo_reg == a_lo_reg) :
        (r_lo_reg[31:0] == a_lo_reg[31:0]));
    assign sts.last = (idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.full = (fill_reg == CNT_W'(ENTRIES));

    // distance classification
    logic [15:0] diff, neg;
    logic newer, too_old;
    logic [4:0] cnt_inc;
    logic [WINDOW_BITS-1:0] bit_sel, win_new;
    logic [4:0] cnt_new;
    logic [15:0] seq_new;
    logic [2:0] oc;
    logic acc;

    always_comb begin
        diff    = seq_reg - r_seq_reg;
        neg     = 16'd0 - diff;
        newer   = (diff != 16'd0) && (diff <= HALF_RANGE);
        too_old = !newer && (diff != 16'd0) && (neg > 16'(WINDOW_BITS - 1));
        cnt_inc = r_cnt_reg + 5'd1;
        bit_sel = '0;
        win_new = r_win_reg;
        cnt_new = 5'd0;
        seq_new = r_seq_reg;
        acc     = 1'b1;
        oc      = OC_NEWER;
        if (too_old) begin
            if (cnt_inc > RESTART_LIMIT) begin
                seq_new = seq_reg;
                win_new = WINDOW_BITS'(1);
                oc      = OC_RESTART;
            end else begin
                cnt_new = cnt_inc;
                acc     = 1'b0;
                oc      = OC_TOO_OLD;
            end
        end else if (!newer) begin
            bit_sel = WINDOW_BITS'(1) << neg[SH_W-1:0];
            if ((r_win_reg & bit_sel) != '0) begin
                acc = 1'b0;
                oc  = OC_DUPLICATE;
            end else begin
                win_new = r_win_reg | bit_sel;
                oc      = OC_IN_WINDOW;
            end
        end else begin
            if (diff < 16'(WINDOW_BITS)) begin
                win_new = (r_win_reg << diff[SH_W-1:0]) | WINDOW_BITS'(1);
            end else begin
                win_new = WINDOW_BITS'(1);
            end
            seq_new = seq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            mem_hi[fill_reg[IDX_W-1:0]]  <= a_hi_reg;
            mem_lo[fill_reg[IDX_W-1:0]]  <= a_lo_reg;
            mem_seq[fill_reg[IDX_W-1:0]] <= seq_reg;
            mem_win[fill_reg[IDX_W-1:0]] <= WINDOW_BITS'(1);
            mem_cnt[fill_reg[IDX_W-1:0]] <= 5'd0;
        end else if (cmd.update) begin
            mem_seq[ridx_reg] <= seq_new;
            mem_win[ridx_reg] <= win_new;
            mem_cnt[ridx_reg] <= cnt_new;
        end
    end

    assign res_accept  = acc;
    assign res_outcome = oc;

endmodule

@@ hdl/dswf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dswf_ctrl
// Sequencer for table search, entry update and result hand-off.
// ----------------------------------------------------------------------------
module dswf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dswf_pkg::dp_sts_t  sts,
    input  logic               res_accept,
    input  logic [2:0]         res_outcome,
    output dswf_pkg::dp_cmd_t  cmd,
    output logic [7:0]         m_tdata
);
    import dswf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic out_v_reg;
    logic [3:0] out_d_reg;
    logic lastrd_reg;

    assign s_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'd0, out_d_reg};

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts.hit) begin
                    cmd.update = 1'b1;
                    state_next = ST_DONE;
                end else if (lastrd_reg) begin
                    cmd.alloc = !sts.full;
                    state_next = ST_DONE;
                end else begin
                    cmd.rd  = 1'b1;
                    cmd.adv = 1'b1;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_CMP && !sts.hit && !lastrd_reg) begin
            cmd.rd = 1'b0;
            state_next = ST_READ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            lastrd_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.rd) lastrd_reg <= sts.last;
            if (m_tvalid && m_tready) out_v_reg <= 1'b0;
            if (state_reg == ST_CMP && (sts.hit || lastrd_reg)) begin
                out_v_reg <= 1'b1;
                if (sts.hit) out_d_reg <= {res_outcome, res_accept};
                else if (sts.full) out_d_reg <= {OC_FULL, 1'b1};
                else out_d_reg <= {OC_NEW, 1'b1};
            end
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.alloc && cmd.update)) else $error("double table write");
`endif

endmodule

@@ hdl/duplicate_seq_window_filter.sv @@
// ----------------------------------------------------------------------------
// duplicate_seq_window_filter
// Per-originator sliding window duplicate filter over a searched entry table.
// ----------------------------------------------------------------------------
// Each input word is searched against the table one entry at a time in index order,
// through the single table read port, until a match or the last of ENTRIES entries.
// A new word is not accepted until the previous result has been taken. Reset: synchronous
// active low, clears valid bits, fill count and mode; table contents are not cleared.
module duplicate_seq_window_filter #(
    parameter int ENTRIES     = 64,
    parameter int WINDOW_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,     // ipv6_mode
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,      // addr_high[63:0], addr_low[127:64], seq_num[143:128]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata       // accept[0], outcome[3:1]
);
    import dswf_pkg::*;

    logic mode_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic acc;
    logic [2:0] oc;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= 1'b0;
        else if (cfg_valid) mode_reg <= cfg_data;
    end

    dswf_datapath #(.ENTRIES(ENTRIES), .WINDOW_BITS(WINDOW_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ipv6_mode(mode_reg),
        .in_addr_high(s_tdata[63:0]), .in_addr_low(s_tdata[127:64]),
        .in_seq(s_tdata[143:128]), .cmd(cmd), .sts(sts),
        .res_accept(acc), .res_outcome(oc)
    );

    dswf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts),
        .res_accept(acc), .res_outcome(oc), .cmd(cmd), .m_tdata(m_tdata)
    );

endmodule
